/* rtl/dwm_pkg.sv */
// ----------------------------------------------------------------------------
// dwm_pkg : shared types and constants for the dictionary word masking filter
// Transaction payloads, command and token codes, parameter defaults.
// ----------------------------------------------------------------------------
package dwm_pkg;

    localparam int DICT_WORDS_DEF = 64;
    localparam int MAX_LEN_DEF    = 10;

    localparam logic [1:0] CMD_DICT_CHAR = 2'd0;
    localparam logic [1:0] CMD_DICT_LEN  = 2'd1;
    localparam logic [1:0] CMD_TEXT_CHAR = 2'd2;
    localparam logic [1:0] CMD_END_LINE  = 2'd3;

    localparam logic [1:0] KIND_LITERAL  = 2'd0;
    localparam logic [1:0] KIND_MASK     = 2'd1;
    localparam logic [1:0] KIND_EOL      = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] entry_index;
        logic [3:0] char_position;
        logic [3:0] word_length;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic [1:0] token_kind;
        logic [7:0] out_char;
        logic       last_of_run;
    } result_t;

endpackage

/* rtl/dictionary_word_masking_filter.sv */
// ----------------------------------------------------------------------------
// dictionary_word_masking_filter : greedy dictionary word censor
// Text passes through a lookahead window; the first dictionary entry that
// prefixes the window is replaced by one mask token.
// ----------------------------------------------------------------------------
//  channel   valid         stall          payload        direction
//  item      item_valid    item_stall     item           in
//  result    result_valid  result_stall   result         out
//  config    cfg_write     -              cfg_data       in
//
//  Dictionary writes and text characters that leave the window short need
//  no decision. A full window adds a decision: entries are scanned one per
//  cycle through the memory read port, up to min(word_count, DICT_WORDS)
//  entries per emitted token. End of line runs at most one decision per
//  window character, then emits the end-of-line token.
//  Reset clears word lengths (valid bits), the window fill and word_count.
//  A stalled result holds the block in its output step; items are taken
//  only when the block is idle.
// ----------------------------------------------------------------------------
module dictionary_word_masking_filter #(
    parameter int DICT_WORDS = dwm_pkg::DICT_WORDS_DEF,
    parameter int MAX_LEN    = dwm_pkg::MAX_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  dwm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output dwm_pkg::result_t result,
    input  logic             cfg_write,
    input  logic [6:0]       cfg_data
);
    import dwm_pkg::*;

    localparam int IDX_W  = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
    localparam int POS_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int FILL_W = $clog2(MAX_LEN + 1);
    localparam int CNT_W  = $clog2(DICT_WORDS + 1);
    localparam int SCAN_W = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PUT, S_EOL} state_t;

    state_t                  state_reg,   state_next;
    logic [SCAN_W-1:0]       scan_reg,    scan_next;
    logic                    chk_reg,     chk_next;
    logic                    flush_reg,   flush_next;
    logic                    hit_reg,     hit_next;
    logic [FILL_W-1:0]       drop_reg,    drop_next;
    logic [FILL_W-1:0]       fill_reg,    fill_next;
    logic [MAX_LEN-1:0][7:0] win_reg,     win_next;
    logic [6:0]              wc_reg;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg,     out_next;

    logic                    accept;
    logic                    out_free;
    logic [SCAN_W-1:0]       limit;
    logic                    match;
    logic [FILL_W-1:0]       match_len;
    logic [FILL_W-1:0]       fill_inc;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign limit        = (int'(wc_reg) > DICT_WORDS) ? SCAN_W'(DICT_WORDS)
                                                      : SCAN_W'(wc_reg);
    assign fill_inc     = FILL_W'(int'(fill_reg) + 1);

    dwm_dict #(
        .DICT_WORDS (DICT_WORDS),
        .MAX_LEN    (MAX_LEN)
    ) u_dict (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept),
        .wr_item   (item),
        .rd_addr   (scan_reg[IDX_W-1:0]),
        .window    (win_reg),
        .fill      (fill_reg),
        .match     (match),
        .match_len (match_len)
    );

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        chk_next       = chk_reg;
        flush_next     = flush_reg;
        hit_next       = hit_reg;
        drop_next      = drop_reg;
        fill_next      = fill_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                scan_next = '0;
                chk_next  = 1'b0;
                if (accept && (item.command == CMD_TEXT_CHAR))
                begin
                    win_next[fill_reg[POS_W-1:0]] = item.char_code;
                    fill_next  = fill_inc;
                    flush_next = 1'b0;
                    if (fill_inc == FILL_W'(MAX_LEN))
                    begin
                        state_next = S_SCAN;
                    end
                end
                else if (accept && (item.command == CMD_END_LINE))
                begin
                    flush_next = 1'b1;
                    state_next = (fill_reg != '0) ? S_SCAN : S_EOL;
                end
            end
            S_SCAN:
            begin
                priority if (chk_reg && match)
                begin
                    hit_next   = 1'b1;
                    drop_next  = match_len;
                    chk_next   = 1'b0;
                    state_next = S_PUT;
                end
                else if (scan_reg < limit)
                begin
                    scan_next = scan_reg + 1'b1;
                    chk_next  = 1'b1;
                end
                else if (!chk_reg)
                begin
                    hit_next   = 1'b0;
                    drop_next  = FILL_W'(1);
                    state_next = S_PUT;
                end
                else
                begin
                    chk_next = 1'b0;
                end
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.token_kind  = hit_reg ? KIND_MASK : KIND_LITERAL;
                    out_next.out_char    = hit_reg ? 8'd0 : win_reg[0];
                    out_next.last_of_run = !flush_reg;
                    win_next             = win_reg >> {drop_reg, 3'b000};
                    fill_next            = fill_reg - drop_reg;
                    scan_next            = '0;
                    chk_next             = 1'b0;
                    if (!flush_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (fill_reg != drop_reg)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EOL;
                    end
                end
            end
            S_EOL:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.token_kind  = KIND_EOL;
                    out_next.out_char    = 8'd0;
                    out_next.last_of_run = 1'b1;
                    fill_next            = '0;
                    flush_next           = 1'b0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            chk_reg       <= 1'b0;
            flush_reg     <= 1'b0;
            fill_reg      <= '0;
            wc_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            chk_reg       <= chk_next;
            flush_reg     <= flush_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            if (cfg_write)
            begin
                wc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        drop_reg <= drop_next;
        win_reg  <= win_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_LEN))
        else $error("window fill beyond capacity");

    a_drop_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |-> (drop_reg != '0) && (drop_reg <= fill_reg))
        else $error("decision drops more than the window holds");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_reg <= limit))
        else $error("scan ran past the searched entries");

    a_full_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.command == CMD_TEXT_CHAR) && (fill_inc == FILL_W'(MAX_LEN)))
        |=> (state_reg == S_SCAN))
        else $error("full window did not start a decision");

    a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.token_kind == KIND_EOL)) |-> result.last_of_run)
        else $error("end-of-line token not marked last");

endmodule

/* rtl/dwm_dict.sv */
// ----------------------------------------------------------------------------
// dwm_dict : dictionary store and entry comparator
// Character rows and word lengths in synchronous memories (registered read);
// the registered row is compared against the lookahead window in parallel.
// ----------------------------------------------------------------------------
module dwm_dict #(
    parameter int  DICT_WORDS = dwm_pkg::DICT_WORDS_DEF,
    parameter int  MAX_LEN    = dwm_pkg::MAX_LEN_DEF,
    localparam int IDX_W      = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1,
    localparam int FILL_W     = $clog2(MAX_LEN + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  dwm_pkg::item_t             wr_item,
    input  logic [IDX_W-1:0]           rd_addr,
    input  logic [MAX_LEN-1:0][7:0]    window,
    input  logic [FILL_W-1:0]          fill,
    output logic                       match,
    output logic [FILL_W-1:0]          match_len
);
    import dwm_pkg::*;

    localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [MAX_LEN-1:0][7:0] chars_mem [DICT_WORDS];
    logic [FILL_W-1:0]       len_mem   [DICT_WORDS];
    logic [DICT_WORDS-1:0]   len_vld_reg;

    logic [MAX_LEN-1:0][7:0] chars_rd_reg;
    logic [FILL_W-1:0]       len_rd_reg;
    logic                    vld_rd_reg;

    logic                    entry_ok;
    logic                    chr_we;
    logic                    len_we;
    logic [IDX_W-1:0]        waddr;
    logic [POS_W-1:0]        wpos;
    logic [FILL_W-1:0]       len_sat;
    logic [FILL_W-1:0]       len_eff;
    logic                    eq;

    assign entry_ok = int'(wr_item.entry_index) < DICT_WORDS;
    assign chr_we   = wr_en && (wr_item.command == CMD_DICT_CHAR) && entry_ok
                      && (int'(wr_item.char_position) < MAX_LEN);
    assign len_we   = wr_en && (wr_item.command == CMD_DICT_LEN) && entry_ok;
    assign waddr    = IDX_W'(wr_item.entry_index);
    assign wpos     = POS_W'(wr_item.char_position);
    assign len_sat  = (int'(wr_item.word_length) > MAX_LEN) ? FILL_W'(MAX_LEN)
                                                            : FILL_W'(wr_item.word_length);

    always_ff @(posedge clk)
    begin
        if (chr_we)
        begin
            chars_mem[waddr][wpos] <= wr_item.char_code;
        end
        if (len_we)
        begin
            len_mem[waddr] <= len_sat;
        end
        chars_rd_reg <= chars_mem[rd_addr];
        len_rd_reg   <= len_mem[rd_addr];
    end

    // valid bits reset to zero: an entry never written reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_vld_reg <= '0;
            vld_rd_reg  <= 1'b0;
        end
        else
        begin
            if (len_we)
            begin
                len_vld_reg[waddr] <= 1'b1;
            end
            vld_rd_reg <= len_vld_reg[rd_addr];
        end
    end

    always_comb
    begin
        len_eff = vld_rd_reg ? len_rd_reg : '0;
        eq      = 1'b1;
        for (int p = 0; p < MAX_LEN; p++)
        begin
            if ((p < int'(len_eff)) && (chars_rd_reg[p] != window[p]))
            begin
                eq = 1'b0;
            end
        end
        match     = (len_eff != '0) && (len_eff <= fill) && eq;
        match_len = len_eff;
    end

endmodule
